@@ design/bfm_pkg.sv @@
// shared types, widths and codes of the brenner focus measure core
package bfm_pkg;

  // fixed field and state widths
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int THR_W      = 9;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 16;
  localparam int SHARP_W    = 24;
  localparam int CFG_IDX_W  = 2;

  // columns skipped at the start of each row, and the smallest usable width
  localparam int SKIP_COLS  = 2;
  localparam int MIN_WIDTH  = 3;

  // entries of the frame job queue between front and back
  localparam int JOB_DEPTH  = 2;

  // defaults of the top level parameters
  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_FRACTION_BITS = 8;

  // register reset values
  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [THR_W-1:0] RST_THRESH = 9'd0;

  // status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_WIDTH = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDX_WIDTH  = 2'd0,
    CFG_IDX_HEIGHT = 2'd1,
    CFG_IDX_THRESH = 2'd2
  } cfg_idx_t;

  // divider sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DENOM,
    ST_DIVIDE,
    ST_DONE
  } div_state_t;

  // job queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ design/bfm_front.sv @@
// front end: configuration registers, pixel counting and squared difference accumulation
module bfm_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bfm_pkg::CFG_W-1:0]              cfg_wdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [bfm_pkg::PIX_W-1:0]              in_tdata,
  input  bfm_pkg::fifo_stat_t                    fifo_stat,
  output logic                                   job_push,
  output logic [bfm_pkg::SUM_W-1:0]              job_sum,
  output logic [$clog2(MAX_WIDTH+1)-1:0]         job_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]        job_h,
  output logic                                   job_err
);
  import bfm_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMPW = (WW > CFG_W) ? WW : CFG_W;
  localparam int HCMPW = (HW > CFG_W) ? HW : CFG_W;

  logic [CFG_W-1:0]       width_r;
  logic [CFG_W-1:0]       height_r;
  logic signed [THR_W-1:0] thresh_r;

  logic [CW-1:0]          col_r,  col_nxt;
  logic [RW-1:0]          row_r,  row_nxt;
  logic [PIX_W-1:0]       p0_r,   p0_nxt;
  logic [PIX_W-1:0]       p1_r,   p1_nxt;
  logic [SUM_W-1:0]       sum_r,  sum_nxt;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [SQ_W-1:0]        s1_sq_r;
  logic                   s1_end_r;
  logic [WW-1:0]          s1_w_r;
  logic [HW-1:0]          s1_h_r;
  logic                   s1_err_r;

  logic [WCMPW-1:0]       w_ext;
  logic [HCMPW-1:0]       h_ext;
  logic [WW-1:0]          w_eff;
  logic [HW-1:0]          h_eff;
  logic [WW:0]            col_p1;
  logic [HW:0]            row_p1;
  logic                   row_end;
  logic                   frame_end;
  logic signed [THR_W-1:0] diff;
  logic signed [2*THR_W-1:0] diff_sq;
  logic                   counted;
  logic                   accept;
  logic                   stall;
  logic                   fire;
  logic [SUM_W-1:0]       sum_plus;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      thresh_r <= RST_THRESH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        CFG_IDX_THRESH: thresh_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp width and height to 1..max
  always_comb begin
    w_ext = WCMPW'(width_r);
    h_ext = HCMPW'(height_r);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WCMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext[WW-1:0];
    end
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > HCMPW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext[HW-1:0];
    end
  end

  // row and frame boundaries
  assign col_p1    = (WW+1)'(col_r) + (WW+1)'(1);
  assign row_p1    = (HW+1)'(row_r) + (HW+1)'(1);
  assign row_end   = (col_p1 >= (WW+1)'(w_eff));
  assign frame_end = row_end && (row_p1 >= (HW+1)'(h_eff));

  // difference two columns back, squared when above threshold
  assign diff    = $signed({1'b0, in_tdata}) - $signed({1'b0, p1_r});
  assign diff_sq = diff * diff;
  assign counted = (col_r >= CW'(SKIP_COLS)) && (diff > thresh_r);

  // handshake: hold off only while a frame end waits for queue space
  assign stall     = s1_valid_r && s1_end_r && fifo_stat.full;
  assign in_tready = !stall;
  assign accept    = in_tvalid && in_tready;
  assign fire      = s1_valid_r && !stall;
  assign sum_plus  = sum_r + SUM_W'(s1_sq_r);

  // counters and pixel history
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    p0_nxt  = p0_r;
    p1_nxt  = p1_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        p0_nxt  = '0;
        p1_nxt  = '0;
        row_nxt = frame_end ? '0 : RW'(row_p1);
      end else begin
        col_nxt = col_p1[CW-1:0];
        p0_nxt  = in_tdata;
        p1_nxt  = p0_r;
      end
    end
  end

  // accumulate in the second stage
  always_comb begin
    sum_nxt      = sum_r;
    s1_valid_nxt = s1_valid_r;
    if (fire) begin
      sum_nxt      = s1_end_r ? '0 : sum_plus;
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      p0_r       <= '0;
      p1_r       <= '0;
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      p0_r       <= p0_nxt;
      p1_r       <= p1_nxt;
      sum_r      <= sum_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // second stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq_r  <= counted ? diff_sq[SQ_W-1:0] : '0;
      s1_end_r <= frame_end;
      s1_w_r   <= w_eff;
      s1_h_r   <= h_eff;
      s1_err_r <= (w_eff < WW'(MIN_WIDTH));
    end
  end

  // frame job toward the divider
  assign job_push = fire && s1_end_r;
  assign job_sum  = sum_plus;
  assign job_w    = s1_w_r;
  assign job_h    = s1_h_r;
  assign job_err  = s1_err_r;

  // checks
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !fifo_stat.full)
    else $error("frame job pushed into a full queue");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> s1_valid_r && $stable(sum_r))
    else $error("stalled frame end lost or accumulator moved");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept && row_end |=> (col_r == '0) && (p1_r == '0))
    else $error("row end did not restart the column");

endmodule

@@ design/bfm_job_fifo.sv @@
// short register queue of finished frame jobs between front and back
module bfm_job_fifo #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DATA_W-1:0]   push_data,
  input  logic                pop,
  output logic [DATA_W-1:0]   pop_data,
  output bfm_pkg::fifo_stat_t stat
);
  import bfm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     count_r,  count_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count_r == NW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/bfm_divider.sv @@
// back end: denominator, bit-serial division, saturation and result register
module bfm_divider #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bfm_pkg::fifo_stat_t               fifo_stat,
  output logic                              job_pop,
  input  logic [bfm_pkg::SUM_W-1:0]         job_sum,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    job_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   job_h,
  input  logic                              job_err,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bfm_pkg::SHARP_W-1:0]       out_sharp,
  output logic                              out_status
);
  import bfm_pkg::*;

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int DW     = WW + HW;
  localparam int QW     = SUM_W + FRACTION_BITS;
  localparam int STEP_W = $clog2(QW + 1);

  div_state_t        state_r, state_nxt;

  logic [SUM_W-1:0]  sum_r;
  logic [WW-1:0]     w_r;
  logic [HW-1:0]     h_r;
  logic              err_r;
  logic [DW-1:0]     den_r;
  logic [DW-1:0]     rem_r;
  logic [QW-1:0]     quo_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [SHARP_W-1:0] sharp_r;
  logic              status_r;

  logic              load_job;
  logic              start_div;
  logic              do_step;
  logic              load_out;
  logic              out_free;
  logic [DW:0]       trial;
  logic              take;
  logic [SHARP_W-1:0] result;

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (!fifo_stat.empty) state_nxt = ST_DENOM;
      ST_DENOM:  state_nxt = err_r ? ST_DONE : ST_DIVIDE;
      ST_DIVIDE: if (step_r == STEP_W'(1)) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load_job  = 1'b0;
    start_div = 1'b0;
    do_step   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:   load_job  = !fifo_stat.empty;
      ST_DENOM:  start_div = !err_r;
      ST_DIVIDE: do_step   = 1'b1;
      ST_DONE:   load_out  = out_free;
      default: ;
    endcase
  end

  assign job_pop = load_job;

  // restoring division step
  assign trial = {rem_r, quo_r[QW-1]};
  assign take  = (trial >= {1'b0, den_r});

  // saturated mean, or zero for a width below three
  always_comb begin
    if (err_r) begin
      result = '0;
    end else if (|quo_r[QW-1:SHARP_W]) begin
      result = '1;
    end else begin
      result = quo_r[SHARP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load_job) begin
      sum_r <= job_sum;
      w_r   <= job_w;
      h_r   <= job_h;
      err_r <= job_err;
    end
    if (start_div) begin
      den_r  <= DW'(h_r) * DW'(w_r - WW'(SKIP_COLS));
      rem_r  <= '0;
      quo_r  <= QW'(sum_r) << FRACTION_BITS;
      step_r <= STEP_W'(QW);
    end
    if (do_step) begin
      rem_r  <= take ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_r  <= {quo_r[QW-2:0], take};
      step_r <= step_r - STEP_W'(1);
    end
    if (load_out) begin
      sharp_r  <= result;
      status_r <= err_r ? STATUS_BAD_WIDTH : STATUS_OK;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_sharp  = sharp_r;
  assign out_status = status_r;

  // checks
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> (den_r != '0))
    else $error("division started with zero denominator");

  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> (step_r != '0))
    else $error("division step counter ran out");

  a_err_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DENOM) && err_r |=> (state_r == ST_DONE))
    else $error("bad width job entered the divider");

endmodule

@@ design/brenner_focus_measure_core.sv @@
// top level of the brenner focus measure core
//
// Pixels of an 8-bit grayscale frame enter in raster order on the in_ stream
// channel, one request per pixel; the core takes one pixel every cycle while
// in_tready is high. Each pixel from the third column on is compared with the
// one two columns back, and the square of a difference above the threshold
// is summed per frame. After the last pixel of a frame one request leaves on
// the out_ channel with the mean squared difference (8 fraction bits by
// default) in out_tdata and the status in out_tuser (1 when the width is
// below three, value 0). out_tvalid rises once the last accepted pixel has
// passed the accumulate stage, queue load, denominator, the 48 steps (at
// defaults) of the one-bit-per-cycle restoring divider and result register;
// for a width below three the divider steps are skipped. Up to two finished
// frames queue between front and back; in_tready drops only when a frame
// ends while the queue is full, so frames of fewer pixels than the division
// time slow the input. A stalled receiver holds the result register; the
// divider finishes its job and the queue fills behind it. Reset is synchronous
// and active low, clears counters, accumulator and queue, and loads width
// 640, height 480, threshold 0. The user must see that configuration is written
// through cfg_we, cfg_index and cfg_wdata only while idle; the core does not enforce it.
module brenner_focus_measure_core #(
  parameter int MAX_WIDTH     = bfm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = bfm_pkg::DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = bfm_pkg::DEF_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bfm_pkg::PIX_W-1:0]     in_tdata,   // [7:0] pixel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bfm_pkg::SHARP_W-1:0]   out_tdata,  // [23:0] sharpness
  output logic                          out_tuser   // [0] status
);
  import bfm_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int JOB_W = SUM_W + WW + HW + 1;

  fifo_stat_t        fifo_stat;
  logic              push;
  logic              pop;
  logic [SUM_W-1:0]  push_sum;
  logic [WW-1:0]     push_w;
  logic [HW-1:0]     push_h;
  logic              push_err;
  logic [JOB_W-1:0]  push_data;
  logic [JOB_W-1:0]  pop_data;
  logic [SUM_W-1:0]  pop_sum;
  logic [WW-1:0]     pop_w;
  logic [HW-1:0]     pop_h;
  logic              pop_err;

  // front end
  bfm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fifo_stat (fifo_stat),
    .job_push  (push),
    .job_sum   (push_sum),
    .job_w     (push_w),
    .job_h     (push_h),
    .job_err   (push_err)
  );

  // job packing
  assign push_data = {push_err, push_h, push_w, push_sum};
  assign {pop_err, pop_h, pop_w, pop_sum} = pop_data;

  bfm_job_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (JOB_DEPTH)
  ) u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  // back end
  bfm_divider #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .job_pop    (pop),
    .job_sum    (pop_sum),
    .job_w      (pop_w),
    .job_h      (pop_h),
    .job_err    (pop_err),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sharp  (out_tdata),
    .out_status (out_tuser)
  );

endmodule
